// ===== sv/rrqs_pkg.sv =====
`default_nettype none

package rrqs_pkg;

  // Ring geometry.
  localparam int unsigned MaxProcs = 16;
  localparam int unsigned SlotW    = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned LiveW    = 5;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned IdW      = 16;
  localparam int unsigned StatusW  = 3;

  // Packed result item width and its byte-padded bus width.
  localparam int unsigned ResW  = StatusW + IdW + TimeW + TimeW + LiveW + 1;
  localparam int unsigned OutDW = ((ResW + 7) / 8) * 8;

  localparam logic [TimeW-1:0] QuantumReset = TimeW'(3);
  localparam logic [IdW-1:0]   IdMax        = {IdW{1'b1}};
  localparam logic [IdW-1:0]   IdFirst      = IdW'(1);

  typedef enum logic [StatusW-1:0] {
    StatAdded    = 3'd0,
    StatFull     = 3'd1,
    StatRan      = 3'd2,
    StatComplete = 3'd3,
    StatIdle     = 3'd4
  } status_e;

  typedef enum logic {
    OpAdd = 1'b0,
    OpRun = 1'b1
  } op_e;

  typedef struct packed {
    logic             all_done;
    logic [LiveW-1:0] jobs_live;
    logic [TimeW-1:0] time_left;
    logic [TimeW-1:0] time_used;
    logic [IdW-1:0]   job_id;
    status_e          status;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/round_robin_quantum_scheduler_unit.sv =====
`default_nettype none

// Round-robin time-slice scheduler.
//
// Input channel (s_axis): one item per command. tuser carries the opcode
// (add a job or run one slice) and tdata carries the execution time of an
// added job. Every item produces exactly one result item on m_axis, which
// packs status, job id, time used, time left, live job count and the
// all-done flag.
//
// Jobs live in three slot memories (id, remaining time, link to the next
// slot) with registered synchronous reads. The slot is read on accept and
// modified and written back in the execute step, which loads the result into
// the output register. A run item and an add into an empty or full ring end
// there; an add into a non-empty ring loads it in an extra link step, since
// the new slot and the old tail both need their links rewritten through one
// write port. A new item is accepted while an earlier result still waits;
// when the receiver stalls with that result pending, the write-back step
// holds and the input stalls behind it. Reset empties the ring, restarts
// job ids at 1 and sets the quantum to 3; the slot memories need no clearing.

module round_robin_quantum_scheduler_unit (
  input  wire                           clk_i,
  input  wire                           rst_ni,

  input  wire                           quantum_we_i,
  input  wire [rrqs_pkg::TimeW-1:0]     quantum_wdata_i,

  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] exec_time
  input  wire [rrqs_pkg::TimeW-1:0]     s_axis_tdata,
  // [0] op
  input  wire                           s_axis_tuser,

  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // [2:0] status, [18:3] job_id, [34:19] time_used, [50:35] time_left,
  // [55:51] jobs_live, [56] all_done, [63:57] zero
  output logic [rrqs_pkg::OutDW-1:0]    m_axis_tdata
);

  localparam int unsigned SlotW = rrqs_pkg::SlotW;
  localparam int unsigned TimeW = rrqs_pkg::TimeW;
  localparam int unsigned IdW   = rrqs_pkg::IdW;
  localparam int unsigned LiveW = rrqs_pkg::LiveW;
  localparam int unsigned Procs = rrqs_pkg::MaxProcs;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExec = 3'b010,
    StLink = 3'b100
  } state_e;

  // Slot memories.
  logic [IdW-1:0]   id_mem   [Procs];
  logic [TimeW-1:0] rem_mem  [Procs];
  logic [SlotW-1:0] link_mem [Procs];

  state_e state_q, state_d;

  logic [Procs-1:0] free_q, free_d;
  logic [SlotW-1:0] tail_q, tail_d;
  logic [SlotW-1:0] cur_q, cur_d;
  logic [SlotW-1:0] prev_q, prev_d;
  logic [LiveW-1:0] live_q, live_d;
  logic [IdW-1:0]   next_id_q, next_id_d;
  logic [TimeW-1:0] quantum_q;

  // Latched item and the slot chosen for an add.
  logic             op_q;
  logic [TimeW-1:0] time_q;
  logic [SlotW-1:0] new_slot_q, new_slot_d;

  // Registered read data.
  logic [IdW-1:0]   rd_id_q;
  logic [TimeW-1:0] rd_rem_q;
  logic [SlotW-1:0] rd_link_q;

  // Output register.
  logic             out_valid_q, out_valid_d;
  rrqs_pkg::result_t out_q, out_d;

  // Memory write controls.
  logic             id_we, rem_we, link_we;
  logic [SlotW-1:0] id_waddr, rem_waddr, link_waddr;
  logic [IdW-1:0]   id_wdata;
  logic [TimeW-1:0] rem_wdata;
  logic [SlotW-1:0] link_wdata;

  logic             in_accept;
  logic [SlotW-1:0] rd_addr;
  logic             out_free;
  logic             have_free;
  logic [SlotW-1:0] free_slot;
  logic             ring_full;
  logic             completes;
  logic [LiveW-1:0] live_dec;

  assign s_axis_tready = (state_q == StIdle);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign rd_addr       = (s_axis_tuser == rrqs_pkg::OpRun) ? cur_q : tail_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = rrqs_pkg::OutDW'(out_q);

  // Lowest free slot.
  always_comb begin
    have_free = 1'b0;
    free_slot = '0;
    for (int i = Procs - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        have_free = 1'b1;
        free_slot = SlotW'(i);
      end
    end
  end

  assign ring_full = !have_free || (live_q >= LiveW'(Procs));
  assign completes = (rd_rem_q <= quantum_q);
  assign live_dec  = live_q - LiveW'(1);

  always_comb begin
    state_d     = state_q;
    free_d      = free_q;
    tail_d      = tail_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    live_d      = live_q;
    next_id_d   = next_id_q;
    new_slot_d  = new_slot_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    id_we      = 1'b0;
    rem_we     = 1'b0;
    link_we    = 1'b0;
    id_waddr   = free_slot;
    rem_waddr  = free_slot;
    link_waddr = free_slot;
    id_wdata   = next_id_q;
    rem_wdata  = time_q;
    link_wdata = rd_link_q;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StExec;
        end
      end

      StExec: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (op_q == rrqs_pkg::OpAdd) begin
            if (ring_full) begin
              out_d.status    = rrqs_pkg::StatFull;
              out_d.jobs_live = live_q;
              state_d         = StIdle;
            end else begin
              // Fill the new slot; in a non-empty ring its link takes the old tail's successor.
              id_we      = 1'b1;
              rem_we     = 1'b1;
              link_we    = 1'b1;
              free_d[free_slot] = 1'b0;
              new_slot_d = free_slot;
              next_id_d  = (next_id_q >= rrqs_pkg::IdMax) ? rrqs_pkg::IdFirst
                                                          : next_id_q + IdW'(1);
              if (live_q == '0) begin
                link_wdata = free_slot;
                tail_d     = free_slot;
                cur_d      = free_slot;
                prev_d     = free_slot;
                live_d     = LiveW'(1);
                out_d.status    = rrqs_pkg::StatAdded;
                out_d.job_id    = next_id_q;
                out_d.time_left = time_q;
                out_d.jobs_live = LiveW'(1);
                state_d = StIdle;
              end else begin
                // Old tail link is rewritten next cycle; result follows.
                out_valid_d = out_valid_q && !m_axis_tready;
                out_d       = out_q;
                state_d     = StLink;
              end
            end
          end else if (live_q == '0) begin
            out_d.status = rrqs_pkg::StatIdle;
            state_d      = StIdle;
          end else if (completes) begin
            free_d[cur_q]  = 1'b1;
            live_d         = live_dec;
            out_d.status    = rrqs_pkg::StatComplete;
            out_d.job_id    = rd_id_q;
            out_d.time_used = rd_rem_q;
            out_d.jobs_live = live_dec;
            if (live_dec == '0) begin
              out_d.all_done = 1'b1;
            end else begin
              // Unlink the finished job from its predecessor.
              link_we    = 1'b1;
              link_waddr = prev_q;
              link_wdata = rd_link_q;
              if (tail_q == cur_q) begin
                tail_d = prev_q;
              end
              cur_d = rd_link_q;
            end
            state_d = StIdle;
          end else begin
            rem_we    = 1'b1;
            rem_waddr = cur_q;
            rem_wdata = rd_rem_q - quantum_q;
            prev_d    = cur_q;
            cur_d     = rd_link_q;
            out_d.status    = rrqs_pkg::StatRan;
            out_d.job_id    = rd_id_q;
            out_d.time_used = quantum_q;
            out_d.time_left = rd_rem_q - quantum_q;
            out_d.jobs_live = live_q;
            state_d = StIdle;
          end
        end
      end

      StLink: begin
        if (out_free) begin
          link_we    = 1'b1;
          link_waddr = tail_q;
          link_wdata = new_slot_q;
          if (prev_q == tail_q) begin
            prev_d = new_slot_q;
          end
          tail_d = new_slot_q;
          live_d = live_q + LiveW'(1);
          out_valid_d     = 1'b1;
          out_d           = '0;
          out_d.status    = rrqs_pkg::StatAdded;
          out_d.job_id    = rd_id_q;
          out_d.time_left = time_q;
          out_d.jobs_live = live_q + LiveW'(1);
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      free_q      <= '1;
      tail_q      <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      live_q      <= '0;
      next_id_q   <= rrqs_pkg::IdFirst;
      quantum_q   <= rrqs_pkg::QuantumReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      tail_q      <= tail_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      live_q      <= live_d;
      next_id_q   <= next_id_d;
      out_valid_q <= out_valid_d;
      if (quantum_we_i) begin
        quantum_q <= quantum_wdata_i;
      end
    end
  end

  // Payload registers. The id of a pending add is parked in rd_id_q for the
  // link step, since the slot's id is not read back.
  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    new_slot_q <= new_slot_d;
    if (in_accept) begin
      op_q   <= s_axis_tuser;
      time_q <= s_axis_tdata;
    end
    if (state_q == StExec && state_d == StLink) begin
      rd_id_q <= next_id_q;
    end else if (in_accept) begin
      rd_id_q <= id_mem[rd_addr];
    end
  end

  // Slot memories: one write port each, read registered on accept.
  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[id_waddr] <= id_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    if (in_accept) begin
      rd_rem_q <= rem_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (in_accept) begin
      rd_link_q <= link_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
